// ----- rtl/gcokt_pkg.sv -----
// ============================================================================
// gcokt_pkg: shared widths and codes of the gap checked ordered key table
// Field widths, request kinds and result status codes used by the channel
// interfaces, the table itself and its port checker.
// ============================================================================
package gcokt_pkg;

    localparam int KEY_W    = 32;
    localparam int GAP_W    = 16;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 3;

    localparam logic [GAP_W-1:0] GAP_RESET = 16'd3;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LIST   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_CLOSE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_LISTED    = 3'd5;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd6;

endpackage

// ----- rtl/gcokt_ifs.sv -----
// ============================================================================
// gcokt_ifs: channel interfaces of the gap checked ordered key table
// Request, response and configuration channels, each with valid and ready.
// ============================================================================
interface gcokt_req_if
    import gcokt_pkg::*;
    ;
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic signed [KEY_W-1:0]  key;

    modport source (output valid, kind, key, input ready);
    modport sink   (input valid, kind, key, output ready);
endinterface

interface gcokt_rsp_if
    import gcokt_pkg::*;
    ;
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [KEY_W-1:0]  key_out;
    logic                     last;

    modport source (output valid, status, key_out, last, input ready);
    modport sink   (input valid, status, key_out, last, output ready);
endinterface

interface gcokt_cfg_if
    import gcokt_pkg::*;
    ;
    logic             valid;
    logic             ready;
    logic [GAP_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/gap_checked_ordered_key_table.sv -----
// ============================================================================
// gap_checked_ordered_key_table: sorted key table with a minimum-gap insert
// Holds up to CAPACITY signed keys in ascending order in one synchronous
// memory and serves insert, search and list requests one at a time.
// ============================================================================
// The table takes one request word at a time and answers it on the response
// channel. An insert scans the memory upward from the lowest key, one read a
// cycle, until it meets the first key not below the new one; the two keys
// around that place are checked against min_gap (a distance less than or
// equal to min_gap is refused as too close), then a full table is refused,
// and otherwise the keys above the place are moved up one entry, top first,
// and the new key is written in. A search uses the same scan and reports an
// exact match. A list request reads the keys out in ascending order, one
// response word per key with last set on the final one, or gives a single
// empty word with key_out zero when nothing is stored. Kind 3 is dropped
// without a response. The memory port, one read and one write per cycle,
// sets the pace: an insert scans up to the place of the new key and then
// moves the keys above it, a search ends after the scan, and a list reads
// each key and emits it before it reads the next. A finished response
// waits in the output register while the next request is already
// accepted. min_gap may be written at any time the table is idle; its
// write channel is always ready. There is no clearing pass after reset:
// only entries below the key count are ever read.
// ============================================================================
module gap_checked_ordered_key_table
    import gcokt_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    gcokt_req_if.sink   req,
    gcokt_rsp_if.source rsp,
    gcokt_cfg_if.sink   cfg
);

    // Address width of the key memory and width of a count up to CAPACITY.
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_SCAN      = 8'b0000_0010,
        S_DECIDE    = 8'b0000_0100,
        S_SHIFT     = 8'b0000_1000,
        S_PLACE     = 8'b0001_0000,
        S_EMIT      = 8'b0010_0000,
        S_LIST_RD   = 8'b0100_0000,
        S_LIST_EMIT = 8'b1000_0000
    } state_t;

    // Keys are stored in offset-binary form (sign bit flipped) so that an
    // unsigned compare gives the signed order and differences never wrap.
    logic [KEY_W-1:0] key_store [CAPACITY];
    logic [KEY_W-1:0] rdata_reg;

    logic             mem_re;
    logic [AW-1:0]    mem_raddr;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [KEY_W-1:0] mem_wdata;

    state_t state_reg, state_next;

    logic [GAP_W-1:0]        gap_reg, gap_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [KIND_W-1:0]       kind_reg, kind_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic [KEY_W-1:0]        ord_reg, ord_next;
    logic [CW-1:0]           idx_reg, idx_next;
    logic [CW-1:0]           lidx_reg, lidx_next;
    logic [CW-1:0]           pos_reg, pos_next;
    logic                    vld_reg, vld_next;
    logic                    more_reg, more_next;
    logic                    prev_valid_reg, prev_valid_next;
    logic [KEY_W-1:0]        prev_reg, prev_next;
    logic                    hi_valid_reg, hi_valid_next;
    logic [KEY_W-1:0]        hi_reg, hi_next;
    logic [STATUS_W-1:0]     pend_status_reg, pend_status_next;

    logic                    out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]     out_status_reg, out_status_next;
    logic signed [KEY_W-1:0] out_key_reg, out_key_next;
    logic                    out_last_reg, out_last_next;

    logic             out_free;
    logic             req_take;
    logic [KEY_W-1:0] gap_wide;
    logic [KEY_W-1:0] diff_hi;
    logic [KEY_W-1:0] diff_lo;
    logic             too_close;
    logic [CW-1:0]    lidx_up;

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign req_take  = req.valid && req.ready;

    assign rsp.valid   = out_valid_reg;
    assign rsp.status  = out_status_reg;
    assign rsp.key_out = out_key_reg;
    assign rsp.last    = out_last_reg;

    // The output register can take a new word when empty or being drained.
    assign out_free = !out_valid_reg || rsp.ready;

    // Neighbor distances are exact: hi is never below ord, prev always is.
    assign gap_wide  = KEY_W'(gap_reg);
    assign diff_hi   = hi_reg - ord_reg;
    assign diff_lo   = ord_reg - prev_reg;
    assign too_close = (hi_valid_reg && (diff_hi <= gap_wide))
                    || (prev_valid_reg && (diff_lo <= gap_wide));

    assign lidx_up = lidx_reg + CW'(1);

    // Key memory: one write port, one read port with registered data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_store[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= key_store[mem_raddr];
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        gap_next         = gap_reg;
        count_next       = count_reg;
        kind_next        = kind_reg;
        key_next         = key_reg;
        ord_next         = ord_reg;
        idx_next         = idx_reg;
        lidx_next        = lidx_reg;
        pos_next         = pos_reg;
        vld_next         = vld_reg;
        more_next        = more_reg;
        prev_valid_next  = prev_valid_reg;
        prev_next        = prev_reg;
        hi_valid_next    = hi_valid_reg;
        hi_next          = hi_reg;
        pend_status_next = pend_status_reg;

        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_key_next    = out_key_reg;
        out_last_next   = out_last_reg;

        mem_re    = 1'b0;
        mem_raddr = idx_reg[AW-1:0];
        mem_we    = 1'b0;
        mem_waddr = pos_reg[AW-1:0];
        mem_wdata = ord_reg;

        if (cfg.valid)
        begin
            gap_next = cfg.data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    kind_next       = req.kind;
                    key_next        = req.key;
                    ord_next        = {~req.key[KEY_W-1], req.key[KEY_W-2:0]};
                    idx_next        = '0;
                    vld_next        = 1'b0;
                    prev_valid_next = 1'b0;
                    hi_valid_next   = 1'b0;
                    case (req.kind)
                        KIND_INSERT, KIND_SEARCH:
                        begin
                            state_next = S_SCAN;
                        end
                        KIND_LIST:
                        begin
                            if (count_reg == '0)
                            begin
                                pend_status_next = ST_EMPTY;
                                state_next       = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_LIST_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // Reads are pipelined: the data of the read issued last
                // cycle is checked while the next one goes out.
                vld_next = 1'b0;
                if (vld_reg && (rdata_reg >= ord_reg))
                begin
                    hi_valid_next = 1'b1;
                    hi_next       = rdata_reg;
                    pos_next      = lidx_reg;
                    state_next    = S_DECIDE;
                end
                else
                begin
                    if (vld_reg)
                    begin
                        prev_valid_next = 1'b1;
                        prev_next       = rdata_reg;
                    end
                    if (idx_reg == count_reg)
                    begin
                        pos_next   = count_reg;
                        state_next = S_DECIDE;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        lidx_next = idx_reg;
                        idx_next  = idx_reg + CW'(1);
                        vld_next  = 1'b1;
                    end
                end
            end

            S_DECIDE:
            begin
                if (kind_reg == KIND_SEARCH)
                begin
                    pend_status_next = (hi_valid_reg && (hi_reg == ord_reg))
                                     ? ST_FOUND : ST_NOT_FOUND;
                    state_next       = S_EMIT;
                end
                else if (too_close)
                begin
                    pend_status_next = ST_TOO_CLOSE;
                    state_next       = S_EMIT;
                end
                else if (count_reg == CW'(CAPACITY))
                begin
                    pend_status_next = ST_FULL;
                    state_next       = S_EMIT;
                end
                else
                begin
                    idx_next   = count_reg - CW'(1);
                    more_next  = (pos_reg != count_reg);
                    vld_next   = 1'b0;
                    state_next = S_SHIFT;
                end
            end

            S_SHIFT:
            begin
                // Move keys up one entry, top first: read entry i, write
                // it to i + 1 in the next cycle.
                vld_next = 1'b0;
                if (vld_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = lidx_up[AW-1:0];
                    mem_wdata = rdata_reg;
                end
                if (more_reg)
                begin
                    mem_re    = 1'b1;
                    lidx_next = idx_reg;
                    vld_next  = 1'b1;
                    if (idx_reg == pos_reg)
                    begin
                        more_next = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg - CW'(1);
                    end
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end

            S_PLACE:
            begin
                mem_we           = 1'b1;
                count_next       = count_reg + CW'(1);
                pend_status_next = ST_INSERTED;
                state_next       = S_EMIT;
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = pend_status_reg;
                    out_key_next    = (pend_status_reg == ST_EMPTY) ? '0 : key_reg;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            S_LIST_RD:
            begin
                mem_re     = 1'b1;
                idx_next   = idx_reg + CW'(1);
                state_next = S_LIST_EMIT;
            end

            S_LIST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_LISTED;
                    out_key_next    = $signed({~rdata_reg[KEY_W-1],
                                               rdata_reg[KEY_W-2:0]});
                    out_last_next   = (idx_reg == count_reg);
                    state_next      = (idx_reg == count_reg) ? S_IDLE : S_LIST_RD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            gap_reg         <= GAP_RESET;
            count_reg       <= '0;
            kind_reg        <= KIND_INSERT;
            key_reg         <= '0;
            ord_reg         <= '0;
            idx_reg         <= '0;
            lidx_reg        <= '0;
            pos_reg         <= '0;
            vld_reg         <= 1'b0;
            more_reg        <= 1'b0;
            prev_valid_reg  <= 1'b0;
            prev_reg        <= '0;
            hi_valid_reg    <= 1'b0;
            hi_reg          <= '0;
            pend_status_reg <= ST_INSERTED;
            out_valid_reg   <= 1'b0;
            out_status_reg  <= ST_INSERTED;
            out_key_reg     <= '0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            gap_reg         <= gap_next;
            count_reg       <= count_next;
            kind_reg        <= kind_next;
            key_reg         <= key_next;
            ord_reg         <= ord_next;
            idx_reg         <= idx_next;
            lidx_reg        <= lidx_next;
            pos_reg         <= pos_next;
            vld_reg         <= vld_next;
            more_reg        <= more_next;
            prev_valid_reg  <= prev_valid_next;
            prev_reg        <= prev_next;
            hi_valid_reg    <= hi_valid_next;
            hi_reg          <= hi_next;
            pend_status_reg <= pend_status_next;
            out_valid_reg   <= out_valid_next;
            out_status_reg  <= out_status_next;
            out_key_reg     <= out_key_next;
            out_last_reg    <= out_last_next;
        end
    end

endmodule

// ----- rtl/gcokt_chk.sv -----
// ============================================================================
// gcokt_chk: port checker of the gap checked ordered key table
// Watches the request and response channels and flags behavior that the
// table must never show.
// ============================================================================
module gcokt_chk
    import gcokt_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    req_valid,
    input logic                    req_ready,
    input logic [KIND_W-1:0]       req_kind,
    input logic                    rsp_valid,
    input logic                    rsp_ready,
    input logic [STATUS_W-1:0]     rsp_status,
    input logic signed [KEY_W-1:0] rsp_key_out,
    input logic                    rsp_last
);

    // A real request keeps the table busy for at least the next cycle.
    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && (req_kind != KIND_UNUSED)) |=> !req_ready)
        else $error("request accepted back to back");

    // A stalled response word holds its payload.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=>
            (rsp_valid && $stable(rsp_status) && $stable(rsp_key_out)
             && $stable(rsp_last)))
        else $error("stalled response word changed");

    // Only listed keys may come without the last mark.
    a_last_only_list: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_last) |-> (rsp_status == ST_LISTED))
        else $error("non-list response without last");

    // An empty list answer carries key zero.
    a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_status == ST_EMPTY)) |-> (rsp_key_out == '0))
        else $error("empty answer with a nonzero key");

endmodule

bind gap_checked_ordered_key_table gcokt_chk u_gcokt_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .req_kind    (req.kind),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_status  (rsp.status),
    .rsp_key_out (rsp.key_out),
    .rsp_last    (rsp.last)
);

// ----- bench/tb_gap_checked_ordered_key_table.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_gap_checked_ordered_key_table: self-checking bench of the key table
// Drives insert, search and list requests into the table and checks every
// response word against a shadow copy of the sorted table. It runs several
// min_gap settings and several idling patterns on both channels.
// ============================================================================
module tb_gap_checked_ordered_key_table;
    import gcokt_pkg::*;

    localparam int  TABLE_DEPTH  = 32;
    localparam int  PHASES       = 8;
    localparam int  PHASE_ITEMS  = 30;
    // Settle long enough that a dropped request cannot still be in progress.
    localparam int  SETTLE_CYCLES = 48;
    localparam int  CYCLE_LIMIT   = 400000;

    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct {
        logic [KIND_W-1:0]       kind;
        logic signed [KEY_W-1:0] key;
    } request_t;

    typedef struct {
        logic [STATUS_W-1:0]     status;
        logic signed [KEY_W-1:0] key_out;
        logic                    last;
    } rsp_word_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    gcokt_req_if req_ch ();
    gcokt_rsp_if rsp_ch ();
    gcokt_cfg_if cfg_ch ();

    gap_checked_ordered_key_table #(
        .CAPACITY (TABLE_DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source),
        .cfg   (cfg_ch.sink)
    );

    always #6 clk = ~clk;

    // Requests waiting to be driven, and the count of requests that have been
    // queued but not yet taken by the table. The count is updated in the same
    // step as the expected words are recorded, so that "idle" is never seen
    // between the two.
    request_t                pending_requests [$];
    int                      outstanding_requests = 0;
    rsp_word_t               expected_words [$];
    logic signed [KEY_W-1:0] inserted_keys [$];

    // Shadow copy of the table: keys in ascending order, the key count and
    // the current min_gap.
    logic signed [KEY_W-1:0] table_keys [TABLE_DEPTH];
    int                      table_count = 0;
    logic [GAP_W-1:0]        table_gap   = GAP_RESET;

    idle_mode_t idle_mode     = IDLE_NONE;
    int         fail_count    = 0;
    int         cycle_count   = 0;

    // Percentage of cycles in which one side holds off under the idle mode.
    function automatic int unsigned idle_pct(input bit receiver_side);
        case (idle_mode)
            IDLE_SENDER:   return receiver_side ? 0 : 84;
            IDLE_RECEIVER: return receiver_side ? 84 : 0;
            IDLE_BOTH:     return 11;
            default:       return 0;
        endcase
    endfunction

    function automatic void record_word(input logic [STATUS_W-1:0] status,
                                        input logic signed [KEY_W-1:0] key_out,
                                        input logic last);
        rsp_word_t word;
        word.status  = status;
        word.key_out = key_out;
        word.last    = last;
        expected_words.push_back(word);
    endfunction

    // Works out the response words of one accepted request and updates the
    // shadow table. Distances are taken in 64 bits, so they never wrap.
    function automatic void predict_request(input logic [KIND_W-1:0] kind,
                                            input logic signed [KEY_W-1:0] key);
        int pos;
        bit too_close;
        pos = 0;
        too_close = 1'b0;
        while (pos < table_count && table_keys[pos] < key)
            pos++;
        case (kind)
            KIND_INSERT:
            begin
                // The gap is checked against both neighbors before fullness.
                if (pos < table_count)
                begin
                    if (longint'(table_keys[pos]) - longint'(key) <= longint'(table_gap))
                        too_close = 1'b1;
                end
                if (pos > 0)
                begin
                    if (longint'(key) - longint'(table_keys[pos-1]) <= longint'(table_gap))
                        too_close = 1'b1;
                end
                if (too_close)
                    record_word(ST_TOO_CLOSE, key, 1'b1);
                else if (table_count >= TABLE_DEPTH)
                    record_word(ST_FULL, key, 1'b1);
                else
                begin
                    for (int i = table_count; i > pos; i--)
                        table_keys[i] = table_keys[i-1];
                    table_keys[pos] = key;
                    table_count++;
                    record_word(ST_INSERTED, key, 1'b1);
                end
            end
            KIND_SEARCH:
            begin
                if (pos < table_count && table_keys[pos] == key)
                    record_word(ST_FOUND, key, 1'b1);
                else
                    record_word(ST_NOT_FOUND, key, 1'b1);
            end
            KIND_LIST:
            begin
                if (table_count == 0)
                    record_word(ST_EMPTY, '0, 1'b1);
                else
                    for (int i = 0; i < table_count; i++)
                        record_word(ST_LISTED, table_keys[i], i == table_count - 1);
            end
            default:
            begin
                // The unused kind is dropped: no word, no change of state.
            end
        endcase
    endfunction

    function automatic void push_request(input logic [KIND_W-1:0] kind,
                                         input logic signed [KEY_W-1:0] key);
        request_t item;
        item.kind = kind;
        item.key  = key;
        pending_requests.push_back(item);
        outstanding_requests++;
        if (kind == KIND_INSERT)
            inserted_keys.push_back(key);
    endfunction

    // Picks a key that is likely to matter: a key already offered for insert
    // or one within a little more than the gap around it, a key near either
    // end of the range, a small key, or any key at all.
    function automatic logic signed [KEY_W-1:0] pick_key(input logic [GAP_W-1:0] gap,
                                                         input bit for_search);
        int unsigned             sel;
        int                      span;
        int                      offset;
        logic signed [KEY_W-1:0] base;
        sel = $urandom_range(0, 99);
        if (inserted_keys.size() != 0 && sel < 45)
        begin
            base = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
            if (for_search && $urandom_range(0, 1))
                return base;
            span   = int'(gap) + 2;
            offset = int'($urandom_range(0, 2 * span)) - span;
            return base + offset;
        end
        if (sel < 60)
        begin
            offset = int'($urandom_range(0, 8));
            return $urandom_range(0, 1) ? KEY_MAX - offset : KEY_MIN + offset;
        end
        if (sel < 75)
            return int'($urandom_range(0, 200)) - 100;
        return $urandom();
    endfunction

    // Waits until every queued request has been taken and every expected
    // word has come back.
    task automatic wait_idle();
        while (outstanding_requests != 0 || expected_words.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_gap(input logic [GAP_W-1:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        table_gap = value;
    endtask

    // Request driver: a word is taken at an edge where valid and ready are
    // both high. The next word goes out right away unless the sender idles.
    always @(posedge clk)
    begin : drive_requests
        request_t next_req;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                predict_request(req_ch.kind, req_ch.key);
                outstanding_requests--;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_requests.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b0))
                begin
                    next_req = pending_requests.pop_front();
                    req_ch.valid <= 1'b1;
                    req_ch.kind  <= next_req.kind;
                    req_ch.key   <= next_req.key;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // Response monitor: each accepted word is compared with the oldest
    // expected word. Ready stalls at random under the idle mode.
    always @(posedge clk)
    begin : check_responses
        rsp_word_t want;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("unexpected response word: status %0d, key_out %0d, last %0d",
                           rsp_ch.status, rsp_ch.key_out, rsp_ch.last);
                    fail_count++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (rsp_ch.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
                        fail_count++;
                    end
                    if (rsp_ch.key_out !== want.key_out)
                    begin
                        $error("key_out: expected %0d, actual %0d", want.key_out,
                               rsp_ch.key_out);
                        fail_count++;
                    end
                    if (rsp_ch.last !== want.last)
                    begin
                        $error("last: expected %0d, actual %0d", want.last, rsp_ch.last);
                        fail_count++;
                    end
                end
            end
            rsp_ch.ready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
        end
    end

    // Watchdog on the length of the run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin : run_phases
        int unsigned      sel;
        int               made;
        logic [GAP_W-1:0] gap;
        logic [KIND_W-1:0] kind;

        req_ch.valid = 1'b0;
        req_ch.kind  = KIND_INSERT;
        req_ch.key   = '0;
        rsp_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset gap of 3. The empty table comes
        // first; then the gap is probed at exactly the gap and one beyond,
        // at both ends of the key range, and for both neighbors.
        push_request(KIND_LIST,   '0);
        push_request(KIND_SEARCH, 32'sd0);
        push_request(KIND_INSERT, 32'sd0);
        push_request(KIND_INSERT, 32'sd3);
        push_request(KIND_INSERT, -32'sd3);
        push_request(KIND_INSERT, -32'sd1);
        push_request(KIND_INSERT, 32'sd4);
        push_request(KIND_INSERT, -32'sd4);
        push_request(KIND_INSERT, KEY_MAX);
        push_request(KIND_INSERT, KEY_MIN);
        push_request(KIND_INSERT, KEY_MAX - 3);
        push_request(KIND_INSERT, KEY_MIN + 3);
        push_request(KIND_INSERT, KEY_MAX - 4);
        push_request(KIND_INSERT, KEY_MIN + 4);
        push_request(KIND_SEARCH, KEY_MAX);
        push_request(KIND_SEARCH, KEY_MIN);
        push_request(KIND_SEARCH, 32'sd4);
        push_request(KIND_SEARCH, 32'sd5);
        push_request(KIND_UNUSED, 32'sh5A5A_A5A5);
        push_request(KIND_SEARCH, 32'sh5A5A_A5A5);
        push_request(KIND_LIST,   32'sh1234_5678);
        push_request(KIND_INSERT, 32'sd8);

        // Random phases. Each starts from an idle table with a new gap, the
        // extremes among them, and one of the four idling patterns in turn.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_idle();
            repeat (SETTLE_CYCLES) @(posedge clk);
            case (ph)
                0:       gap = '0;
                1:       gap = 16'hFFFF;
                2:       gap = GAP_W'($urandom_range(4, 4000));
                3:       gap = 16'd1;
                4:       gap = 16'h8000;
                5:       gap = GAP_W'($urandom_range(0, 65535));
                6:       gap = '0;
                default: gap = GAP_RESET;
            endcase
            write_gap(gap);
            idle_mode = idle_mode_t'(ph % 4);

            // Mostly inserts and searches around keys already offered, with
            // lists throughout; dropped kinds do not count toward the phase.
            made = 0;
            while (made < PHASE_ITEMS)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 40)
                    kind = KIND_INSERT;
                else if (sel < 75)
                    kind = KIND_SEARCH;
                else if (sel < 93)
                    kind = KIND_LIST;
                else
                    kind = KIND_UNUSED;
                push_request(kind, pick_key(gap, kind == KIND_SEARCH));
                if (kind != KIND_UNUSED)
                    made++;
            end
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && expected_words.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
